// File: design/fld_pkg.sv
// ----------------------------------------------------------------------------
// fld_pkg: shared types and constants for the file-list deframer
// Field sizes, result kind codes, parser phase codes and the record passed
// from the parser to the result emitter.
// ----------------------------------------------------------------------------
package fld_pkg;

  // Message field sizes in bytes
  localparam logic [3:0] COUNT_BYTES = 4'd4;
  localparam logic [3:0] NLEN_BYTES  = 4'd2;
  localparam logic [3:0] SIZE_BYTES  = 4'd8;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_OK    = 2'd2,
    KIND_FAIL  = 2'd3
  } kind_e;

  // Parser phases, one-hot
  typedef enum logic [4:0] {
    PH_COUNT = 5'b00001,
    PH_NLEN  = 5'b00010,
    PH_NAME  = 5'b00100,
    PH_SIZE  = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_e;

  // Everything one byte produces: an optional parse result and an
  // optional end-of-message status
  typedef struct packed {
    logic        has_res;
    kind_e       res_kind;
    logic [7:0]  res_char;
    logic [31:0] res_entry;
    logic [63:0] res_size;
    logic        has_end;
    kind_e       end_kind;
    logic [31:0] end_entry;
  } pair_t;

endpackage

// File: design/fld_in_if.sv
// ----------------------------------------------------------------------------
// fld_in_if: byte request channel
// One message byte per request, with a flag on the final byte.
// ----------------------------------------------------------------------------
interface fld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_message;

  modport source (output valid, output byte_value, output end_of_message, input ready);
  modport sink   (input valid, input byte_value, input end_of_message, output ready);
endinterface

// File: design/fld_out_if.sv
// ----------------------------------------------------------------------------
// fld_out_if: result request channel
// One parse or status result per request.
// ----------------------------------------------------------------------------
interface fld_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  name_char;
  logic [31:0] entry_number;
  logic [63:0] file_size;
  logic        final_result;

  modport source (output valid, output kind, output name_char, output entry_number,
                  output file_size, output final_result, input ready);
  modport sink   (input valid, input kind, input name_char, input entry_number,
                  input file_size, input final_result, output ready);
endinterface

// File: design/fld_parser.sv
// ----------------------------------------------------------------------------
// fld_parser: input register and message parse state
// Holds one byte, updates the field state when the byte is consumed and
// hands the resulting record to the emitter.
// ----------------------------------------------------------------------------
module fld_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  fld_in_if.sink         in_i,
  output fld_pkg::pair_t pair_o,
  output logic           pair_valid_o,
  input  logic           pair_ready_i
);
  import fld_pkg::*;

  // input register
  logic       ib_valid_q;
  logic [7:0] ib_byte_q;
  logic       ib_eom_q;

  // parse state
  phase_e      phase_q, phase_d;
  logic [3:0]  fbc_q, fbc_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] left_q, left_d;
  logic [15:0] name_q, name_d;
  logic [63:0] size_q, size_d;
  logic [31:0] ent_q, ent_d;

  logic [3:0]  fbc_inc;
  logic [31:0] cnt_new;
  logic [15:0] name_new;
  logic [15:0] name_dec;
  logic [63:0] size_new;
  logic [31:0] left_dec;
  pair_t       pair;
  logic        produces;
  logic        consume;

  assign fbc_inc  = fbc_q + 4'd1;
  assign cnt_new  = {cnt_q[23:0], ib_byte_q};
  assign name_new = {name_q[7:0], ib_byte_q};
  assign name_dec = name_q - 16'd1;
  assign size_new = {size_q[55:0], ib_byte_q};
  assign left_dec = left_q - 32'd1;

  // next state and output record for the held byte
  always_comb begin
    phase_d = phase_q;
    fbc_d   = fbc_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    name_d  = name_q;
    size_d  = size_q;
    ent_d   = ent_q;

    pair           = '0;
    pair.res_kind  = KIND_NAME;
    pair.end_kind  = KIND_FAIL;

    case (phase_q)
      PH_COUNT: begin
        cnt_d = cnt_new;
        fbc_d = fbc_inc;
        if (fbc_inc == COUNT_BYTES) begin
          fbc_d   = '0;
          left_d  = cnt_new;
          ent_d   = '0;
          phase_d = (cnt_new == 32'd0) ? PH_DONE : PH_NLEN;
        end
      end
      PH_NLEN: begin
        name_d = name_new;
        fbc_d  = fbc_inc;
        if (fbc_inc == NLEN_BYTES) begin
          fbc_d   = '0;
          size_d  = '0;
          phase_d = (name_new == 16'd0) ? PH_SIZE : PH_NAME;
        end
      end
      PH_NAME: begin
        pair.has_res   = 1'b1;
        pair.res_kind  = KIND_NAME;
        pair.res_char  = ib_byte_q;
        pair.res_entry = ent_q;
        name_d         = name_dec;
        if (name_dec == 16'd0) begin
          phase_d = PH_SIZE;
        end
      end
      PH_SIZE: begin
        size_d = size_new;
        fbc_d  = fbc_inc;
        if (fbc_inc == SIZE_BYTES) begin
          pair.has_res   = 1'b1;
          pair.res_kind  = KIND_ENTRY;
          pair.res_entry = ent_q;
          pair.res_size  = size_new;
          fbc_d          = '0;
          size_d         = '0;
          ent_d          = ent_q + 32'd1;
          left_d         = left_dec;
          phase_d        = (left_dec == 32'd0) ? PH_DONE : PH_NLEN;
        end
      end
      default: ;  // done: trailing bytes are ignored
    endcase

    // end of message: report status and start over
    if (ib_eom_q) begin
      pair.has_end   = 1'b1;
      pair.end_kind  = (phase_d == PH_DONE) ? KIND_OK : KIND_FAIL;
      pair.end_entry = ent_d;
      phase_d        = PH_COUNT;
      fbc_d          = '0;
      cnt_d          = '0;
      left_d         = '0;
      name_d         = '0;
      size_d         = '0;
      ent_d          = '0;
    end
  end

  // a byte with nothing to report needs no room downstream
  assign produces     = pair.has_res | pair.has_end;
  assign consume      = ib_valid_q & (pair_ready_i | ~produces);
  assign pair_valid_o = ib_valid_q & produces;
  assign pair_o       = pair;
  assign in_i.ready   = ~ib_valid_q | consume;

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ib_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      ib_valid_q <= in_i.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ib_byte_q <= in_i.byte_value;
      ib_eom_q  <= in_i.end_of_message;
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COUNT;
      fbc_q   <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
      name_q  <= '0;
      size_q  <= '0;
      ent_q   <= '0;
    end else if (consume) begin
      phase_q <= phase_d;
      fbc_q   <= fbc_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      name_q  <= name_d;
      size_q  <= size_d;
      ent_q   <= ent_d;
    end
  end

endmodule

// File: design/fld_emitter.sv
// ----------------------------------------------------------------------------
// fld_emitter: result register
// Holds one parser record and presents its results one request at a time,
// parse result first, then the end-of-message status.
// ----------------------------------------------------------------------------
module fld_emitter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fld_pkg::pair_t pair_i,
  input  logic           pair_valid_i,
  output logic           pair_ready_o,
  fld_out_if.source      out_o
);
  import fld_pkg::*;

  pair_t pair_q;
  logic  held_q;
  logic  second_q;   // showing the status part of the record
  logic  show_end;
  logic  last_part;
  logic  pop;

  assign show_end  = second_q | ~pair_q.has_res;
  assign last_part = show_end | ~pair_q.has_end;
  assign pop       = held_q & out_o.ready;

  assign pair_ready_o = ~held_q | (pop & last_part);

  // result fields
  always_comb begin
    out_o.valid = held_q;
    if (show_end) begin
      out_o.kind         = pair_q.end_kind;
      out_o.name_char    = '0;
      out_o.entry_number = pair_q.end_entry;
      out_o.file_size    = '0;
      out_o.final_result = 1'b1;
    end else begin
      out_o.kind         = pair_q.res_kind;
      out_o.name_char    = pair_q.res_char;
      out_o.entry_number = pair_q.res_entry;
      out_o.file_size    = pair_q.res_size;
      out_o.final_result = ~pair_q.has_end;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= 1'b0;
      second_q <= 1'b0;
    end else if (pair_valid_i && pair_ready_o) begin
      held_q   <= 1'b1;
      second_q <= 1'b0;
    end else if (pop) begin
      if (last_part) begin
        held_q   <= 1'b0;
        second_q <= 1'b0;
      end else begin
        second_q <= 1'b1;
      end
    end
  end

  // record payload
  always_ff @(posedge clk_i) begin
    if (pair_valid_i && pair_ready_o) begin
      pair_q <= pair_i;
    end
  end

endmodule

// File: design/file_list_meta_deframer_unit.sv
// ----------------------------------------------------------------------------
// file_list_meta_deframer_unit: streaming file-list message parser
// Parses count, name lengths, names and sizes; reports per-message status.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  takes one message byte per request, end_of_message set on the
//         last byte. out_o gives name bytes (kind 0), completed entries with
//         their size (kind 1) and one status per message (2 ok, 3 failed);
//         final_result marks the last result caused by a byte.
//   A byte accepted into the input register is parsed there, and its first
//   result shows on out_o once the result register has loaded it; the result
//   register loads when it is empty or its last result is being taken.
//   Throughput: one byte per cycle while the receiver takes each result. A
//   byte that carries the end flag and also completes a name byte or entry
//   yields two results, so the input stalls until the second one is taken.
//   Bytes that yield nothing pass through the input register without
//   waiting on the output.
//   Reset clears the parse state to the start of a message and drops any
//   held byte or result. When the receiver stalls, the result holds and
//   the input register fills, then in_i.ready drops.
// ----------------------------------------------------------------------------
module file_list_meta_deframer_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  fld_in_if.sink    in_i,
  fld_out_if.source out_o
);
  import fld_pkg::*;

  pair_t pair;
  logic  pair_valid;
  logic  pair_ready;

  fld_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .pair_o       (pair),
    .pair_valid_o (pair_valid),
    .pair_ready_i (pair_ready)
  );

  fld_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pair_i       (pair),
    .pair_valid_i (pair_valid),
    .pair_ready_o (pair_ready),
    .out_o        (out_o)
  );

endmodule
